// File: hdl/rssrb_pkg.sv
// Shared types and constants for the receive-steering table rebalancer.
// No dependencies; the top level and the port checker refer to it by scoped names, the bench files import it.
package rssrb_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int MAX_CORES   = 16;
  localparam int ADDR_W      = 7;   // table entry address
  localparam int CORE_W      = 4;   // stored core id
  localparam int NCORE_W     = 5;   // core count, 0..16
  localparam int CNT_W       = 8;   // entry counts and loads
  localparam int CFG_W       = 8;   // widest config register

  localparam logic [CNT_W-1:0] LOAD_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_UP   = 2'd1,
    OP_DOWN = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic {
    CFG_TABLE_ENTRIES = 1'b0,
    CFG_CORES_IN_USE  = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_RD_DONE,
    S_INIT,
    S_MCLR,
    S_DIV,
    S_UP_NEXT,
    S_MAX,
    S_PROBE_RD,
    S_PROBE_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_MIN,
    S_DN_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [NCORE_W-1:0] old_cores;
    logic [NCORE_W-1:0] new_cores;
    logic [ADDR_W-1:0]  entry_index;
    logic [CORE_W-1:0]  core_query;
  } in_t;

  typedef struct packed {
    logic               status;
    logic [CNT_W-1:0]   changed_count;
    logic [CORE_W-1:0]  entry_core;
    logic               entry_changed;
    logic [CNT_W-1:0]   core_count;
  } out_t;

endpackage

// File: hdl/rssrb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rssrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/rss_redirection_rebalancer.sv
// Receive-steering table rebalancer, top level. Uses rssrb_pkg and rssrb_ram.
// Throughput: one word in flight; the next word is taken once the result leaves.
// Reset (sync, rst_n low): a clearing pass writes core 0 / mark 0 to every entry;
//   core 0 starts owning 128 entries. Config writes are taken whenever rst_n is high.
module rss_redirection_rebalancer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [rssrb_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rssrb_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rssrb_pkg::out_t                  out_data
);

  localparam int CW = rssrb_pkg::CNT_W;
  localparam int KW = rssrb_pkg::NCORE_W;
  localparam int RW = rssrb_pkg::CORE_W;
  localparam int AW = rssrb_pkg::ADDR_W;

  // configuration
  logic [CW-1:0] te_r;
  logic [KW-1:0] ciu_r;

  // control
  rssrb_pkg::state_t state_r, state_nxt;
  rssrb_pkg::in_t    cmd_r, cmd_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;       // sweep index, 0..128
  logic [RW-1:0]     deal_r, deal_nxt;     // init round robin core
  logic [CW-1:0]     cnt_r, cnt_nxt;       // entries moved
  logic [CW-1:0]     rem_r, rem_nxt;       // division remainder
  logic [CW-1:0]     share_r, share_nxt;   // entries per new core
  logic [KW-1:0]     j_r, j_nxt;           // receiving core
  logic [CW-1:0]     xfer_r, xfer_nxt;     // transfers to core j so far
  logic [AW-1:0]     k_r, k_nxt;           // persistent scan position
  logic [CW-1:0]     probes_r, probes_nxt;
  logic [KW-1:0]     scan_r, scan_nxt;     // core scan index
  logic [RW-1:0]     best_r, best_nxt;
  logic [CW-1:0]     bestv_r, bestv_nxt;
  logic [RW-1:0]     oc_r, oc_nxt;         // old core of the entry moved down
  logic [CW-1:0]     load_r [rssrb_pkg::MAX_CORES];
  logic [CW-1:0]     load_nxt [rssrb_pkg::MAX_CORES];

  logic              out_valid_r, out_valid_nxt;
  rssrb_pkg::out_t   out_r, out_nxt;

  // memories
  logic          tbl_we, mark_we;
  logic [AW-1:0] tbl_waddr, mark_waddr, rd_addr;
  logic [RW-1:0] tbl_wdata, tbl_rdata;
  logic          mark_wdata, mark_rdata;

  rssrb_ram #(.WIDTH(RW), .DEPTH(rssrb_pkg::TABLE_DEPTH)) u_tbl (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .raddr(rd_addr),
    .rdata(tbl_rdata)
  );

  rssrb_ram #(.WIDTH(1), .DEPTH(rssrb_pkg::TABLE_DEPTH)) u_mark (
    .clk  (clk),
    .we   (mark_we),
    .waddr(mark_waddr),
    .wdata(mark_wdata),
    .raddr(rd_addr),
    .rdata(mark_rdata)
  );

  // entries in use, capped at table depth
  logic [CW-1:0] n_used;
  assign n_used = (te_r >= CW'(rssrb_pkg::TABLE_DEPTH)) ? CW'(rssrb_pkg::TABLE_DEPTH) : te_r;

  logic accept, bad_cmd, sweep_last, scan_load_ge, scan_load_lt;
  logic [CW-1:0] scan_load;
  logic [CW:0]   k_inc;

  assign in_stall   = (state_r != rssrb_pkg::S_IDLE) || out_valid_r;
  assign accept     = in_valid && !in_stall;
  assign sweep_last = (ptr_r == CW'(rssrb_pkg::TABLE_DEPTH - 1));
  assign scan_load  = load_r[scan_r[RW-1:0]];
  assign scan_load_ge = (scan_load >= bestv_r);
  assign scan_load_lt = (scan_load < bestv_r);
  assign k_inc      = {2'b00, k_r} + (CW+1)'(1);

  // command legality, checked on the incoming word
  always_comb begin
    case (in_data.op)
      rssrb_pkg::OP_INIT: bad_cmd = (ciu_r == '0) || (ciu_r > KW'(rssrb_pkg::MAX_CORES));
      rssrb_pkg::OP_UP:   bad_cmd = (in_data.old_cores == '0) ||
                                    (in_data.old_cores >= in_data.new_cores) ||
                                    (in_data.new_cores > KW'(rssrb_pkg::MAX_CORES));
      rssrb_pkg::OP_DOWN: bad_cmd = (in_data.new_cores == '0) ||
                                    (in_data.new_cores >= in_data.old_cores) ||
                                    (in_data.old_cores > KW'(rssrb_pkg::MAX_CORES));
      default:            bad_cmd = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rssrb_pkg::S_CLR: begin
        if (sweep_last) state_nxt = rssrb_pkg::S_IDLE;
      end
      rssrb_pkg::S_IDLE: begin
        if (accept && !bad_cmd) begin
          case (in_data.op)
            rssrb_pkg::OP_INIT: state_nxt = rssrb_pkg::S_INIT;
            rssrb_pkg::OP_READ: state_nxt = rssrb_pkg::S_RD;
            default:            state_nxt = rssrb_pkg::S_MCLR;
          endcase
        end
      end
      rssrb_pkg::S_RD:      state_nxt = rssrb_pkg::S_RD_DONE;
      rssrb_pkg::S_RD_DONE: state_nxt = rssrb_pkg::S_IDLE;
      rssrb_pkg::S_INIT: begin
        if (sweep_last) state_nxt = rssrb_pkg::S_DONE;
      end
      rssrb_pkg::S_MCLR: begin
        if (sweep_last) begin
          state_nxt = (cmd_r.op == rssrb_pkg::OP_UP) ? rssrb_pkg::S_DIV : rssrb_pkg::S_DN_RD;
        end
      end
      rssrb_pkg::S_DIV: begin
        if (rem_r < CW'(cmd_r.new_cores)) state_nxt = rssrb_pkg::S_UP_NEXT;
      end
      rssrb_pkg::S_UP_NEXT: begin
        if (j_r == cmd_r.new_cores) state_nxt = rssrb_pkg::S_DONE;
        else if (xfer_r != share_r) state_nxt = rssrb_pkg::S_MAX;
      end
      rssrb_pkg::S_MAX: begin
        if (scan_r == cmd_r.old_cores) state_nxt = rssrb_pkg::S_PROBE_RD;
      end
      rssrb_pkg::S_PROBE_RD: begin
        state_nxt = (probes_r == n_used) ? rssrb_pkg::S_UP_NEXT : rssrb_pkg::S_PROBE_CMP;
      end
      rssrb_pkg::S_PROBE_CMP: begin
        state_nxt = (tbl_rdata == best_r) ? rssrb_pkg::S_UP_NEXT : rssrb_pkg::S_PROBE_RD;
      end
      rssrb_pkg::S_DN_RD: begin
        state_nxt = (ptr_r == n_used) ? rssrb_pkg::S_DONE : rssrb_pkg::S_DN_CMP;
      end
      rssrb_pkg::S_DN_CMP: begin
        state_nxt = (KW'(tbl_rdata) >= cmd_r.new_cores) ? rssrb_pkg::S_MIN : rssrb_pkg::S_DN_RD;
      end
      rssrb_pkg::S_MIN: begin
        if (scan_r == cmd_r.new_cores) state_nxt = rssrb_pkg::S_DN_WR;
      end
      rssrb_pkg::S_DN_WR: state_nxt = rssrb_pkg::S_DN_RD;
      rssrb_pkg::S_DONE:  state_nxt = rssrb_pkg::S_IDLE;
      default:            state_nxt = rssrb_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_nxt    = cmd_r;
    ptr_nxt    = ptr_r;
    deal_nxt   = deal_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    share_nxt  = share_r;
    j_nxt      = j_r;
    xfer_nxt   = xfer_r;
    k_nxt      = k_r;
    probes_nxt = probes_r;
    scan_nxt   = scan_r;
    best_nxt   = best_r;
    bestv_nxt  = bestv_r;
    oc_nxt     = oc_r;
    load_nxt   = load_r;
    out_nxt    = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    tbl_we     = 1'b0;
    mark_we    = 1'b0;
    tbl_waddr  = ptr_r[AW-1:0];
    mark_waddr = ptr_r[AW-1:0];
    tbl_wdata  = '0;
    mark_wdata = 1'b0;
    rd_addr    = ptr_r[AW-1:0];

    case (state_r)
      rssrb_pkg::S_CLR: begin
        tbl_we  = 1'b1;
        mark_we = 1'b1;
        ptr_nxt = sweep_last ? '0 : ptr_r + CW'(1);
      end
      rssrb_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_data;
          ptr_nxt  = '0;
          deal_nxt = '0;
          cnt_nxt  = '0;
          if (bad_cmd) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.status = 1'b1;
          end else if (in_data.op == rssrb_pkg::OP_INIT) begin
            for (int c = 0; c < rssrb_pkg::MAX_CORES; c++) load_nxt[c] = '0;
          end
        end
      end
      rssrb_pkg::S_RD: begin
        rd_addr = cmd_r.entry_index;
      end
      rssrb_pkg::S_RD_DONE: begin
        out_valid_nxt         = 1'b1;
        out_nxt               = '0;
        out_nxt.entry_core    = tbl_rdata;
        out_nxt.entry_changed = mark_rdata;
        out_nxt.core_count    = load_r[cmd_r.core_query];
      end
      rssrb_pkg::S_INIT: begin
        mark_we    = 1'b1;
        mark_wdata = (ptr_r < n_used);
        if (ptr_r < n_used) begin
          tbl_we    = 1'b1;
          tbl_wdata = deal_r;
          if (load_r[deal_r] < rssrb_pkg::LOAD_MAX) load_nxt[deal_r] = load_r[deal_r] + CW'(1);
          cnt_nxt   = cnt_r + CW'(1);
          deal_nxt  = (KW'(deal_r) + KW'(1) == ciu_r) ? '0 : deal_r + RW'(1);
        end
        ptr_nxt = ptr_r + CW'(1);
      end
      rssrb_pkg::S_MCLR: begin
        mark_we = 1'b1;
        ptr_nxt = sweep_last ? '0 : ptr_r + CW'(1);
        rem_nxt   = n_used;
        share_nxt = '0;
      end
      rssrb_pkg::S_DIV: begin
        if (rem_r >= CW'(cmd_r.new_cores)) begin
          rem_nxt   = rem_r - CW'(cmd_r.new_cores);
          share_nxt = share_r + CW'(1);
        end else begin
          j_nxt    = cmd_r.old_cores;
          xfer_nxt = '0;
          k_nxt    = '0;
        end
      end
      rssrb_pkg::S_UP_NEXT: begin
        if (j_r != cmd_r.new_cores) begin
          if (xfer_r == share_r) begin
            j_nxt    = j_r + KW'(1);
            xfer_nxt = '0;
          end else begin
            scan_nxt  = '0;
            best_nxt  = '0;
            bestv_nxt = '0;
          end
        end
      end
      rssrb_pkg::S_MAX: begin
        // last most-loaded core wins ties
        if (scan_r != cmd_r.old_cores) begin
          if (scan_load_ge) begin
            bestv_nxt = scan_load;
            best_nxt  = scan_r[RW-1:0];
          end
          scan_nxt = scan_r + KW'(1);
        end else begin
          probes_nxt = '0;
        end
      end
      rssrb_pkg::S_PROBE_RD: begin
        rd_addr = k_r;
        if (probes_r == n_used) xfer_nxt = xfer_r + CW'(1);   // donor absent: skip
      end
      rssrb_pkg::S_PROBE_CMP: begin
        if (tbl_rdata == best_r) begin
          tbl_we     = 1'b1;
          mark_we    = 1'b1;
          tbl_waddr  = k_r;
          mark_waddr = k_r;
          tbl_wdata  = j_r[RW-1:0];
          mark_wdata = 1'b1;
          if (load_r[best_r] != '0) load_nxt[best_r] = load_r[best_r] - CW'(1);
          if (load_r[j_r[RW-1:0]] < rssrb_pkg::LOAD_MAX) begin
            load_nxt[j_r[RW-1:0]] = load_r[j_r[RW-1:0]] + CW'(1);
          end
          cnt_nxt  = cnt_r + CW'(1);
          xfer_nxt = xfer_r + CW'(1);
        end else begin
          k_nxt      = (k_inc == (CW+1)'(n_used)) ? '0 : k_inc[AW-1:0];
          probes_nxt = probes_r + CW'(1);
        end
      end
      rssrb_pkg::S_DN_RD: begin
        rd_addr = ptr_r[AW-1:0];
      end
      rssrb_pkg::S_DN_CMP: begin
        if (KW'(tbl_rdata) >= cmd_r.new_cores) begin
          oc_nxt    = tbl_rdata;
          scan_nxt  = KW'(1);
          best_nxt  = '0;
          bestv_nxt = load_r[0];
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      rssrb_pkg::S_MIN: begin
        // first least-loaded core wins ties
        if (scan_r != cmd_r.new_cores) begin
          if (scan_load_lt) begin
            bestv_nxt = scan_load;
            best_nxt  = scan_r[RW-1:0];
          end
          scan_nxt = scan_r + KW'(1);
        end
      end
      rssrb_pkg::S_DN_WR: begin
        tbl_we     = 1'b1;
        mark_we    = 1'b1;
        tbl_wdata  = best_r;
        mark_wdata = 1'b1;
        if (load_r[oc_r] != '0) load_nxt[oc_r] = load_r[oc_r] - CW'(1);
        if (load_r[best_r] < rssrb_pkg::LOAD_MAX) load_nxt[best_r] = load_r[best_r] + CW'(1);
        cnt_nxt = cnt_r + CW'(1);
        ptr_nxt = ptr_r + CW'(1);
      end
      rssrb_pkg::S_DONE: begin
        out_valid_nxt         = 1'b1;
        out_nxt               = '0;
        out_nxt.changed_count = cnt_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rssrb_pkg::S_CLR;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
      te_r        <= CW'(rssrb_pkg::TABLE_DEPTH);
      ciu_r       <= KW'(1);
      // core 0 owns the whole table
      for (int c = 0; c < rssrb_pkg::MAX_CORES; c++) begin
        load_r[c] <= (c == 0) ? CW'(rssrb_pkg::TABLE_DEPTH) : '0;
      end
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      load_r      <= load_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rssrb_pkg::CFG_TABLE_ENTRIES: te_r  <= cfg_wdata;
          rssrb_pkg::CFG_CORES_IN_USE:  ciu_r <= cfg_wdata[KW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload and working registers, no reset
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    deal_r   <= deal_nxt;
    cnt_r    <= cnt_nxt;
    rem_r    <= rem_nxt;
    share_r  <= share_nxt;
    j_r      <= j_nxt;
    xfer_r   <= xfer_nxt;
    k_r      <= k_nxt;
    probes_r <= probes_nxt;
    scan_r   <= scan_nxt;
    best_r   <= best_nxt;
    bestv_r  <= bestv_nxt;
    oc_r     <= oc_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hdl/rssrb_checker.sv
// Port-level checks for the rebalancer, bound to the top level.
// Uses rssrb_pkg for the word types.
module rssrb_props (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input rssrb_pkg::out_t out_data
);

  // one word in flight: an accepted word blocks the next
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |->
      out_data.changed_count == '0 && out_data.core_count == '0)
    else $error("rejected command carries data");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("output or input open after reset");

endmodule

bind rss_redirection_rebalancer rssrb_props u_rssrb_props (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// File: bench/rssrb_checker.sv
// Checker for the steering table rebalancer: watches config, input and result ports,
// predicts each result from its own copy of table, loads and marks. Needs rssrb_pkg.
module rssrb_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [rssrb_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  rssrb_pkg::in_t              in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  rssrb_pkg::out_t             out_data,
  output int                          fail_count,
  output int                          outstanding
);
  import rssrb_pkg::*;

  logic [CORE_W-1:0]  steer [TABLE_DEPTH];
  logic [CNT_W-1:0]   load [MAX_CORES];
  logic               mark [TABLE_DEPTH];
  logic [7:0]         tbl_entries;
  logic [4:0]         cores_used;
  out_t               expected_q [$];

  function automatic out_t rebalance(in_t w);
    out_t r;
    int n, oldc, newc, share, k, c, v, nc, oc, moved;
    bit found;
    r = '0;
    oldc = int'(w.old_cores);
    newc = int'(w.new_cores);
    n = (tbl_entries < TABLE_DEPTH) ? int'(tbl_entries) : TABLE_DEPTH;
    moved = 0;
    case (w.op)
      OP_INIT: begin
        if (cores_used == 0 || cores_used > MAX_CORES) begin
          r.status = 1'b1;
        end else begin
          c = 0;
          foreach (load[x]) load[x] = '0;
          foreach (mark[x]) mark[x] = 1'b0;
          for (int i = 0; i < n; i++) begin
            if (load[c] < LOAD_MAX) load[c]++;
            steer[i] = CORE_W'(c);
            mark[i] = 1'b1;
            c = (c + 1) % int'(cores_used);
          end
          r.changed_count = CNT_W'(n);
        end
      end
      OP_UP: begin
        if (oldc == 0 || oldc >= newc || newc > MAX_CORES) begin
          r.status = 1'b1;
        end else begin
          foreach (mark[x]) mark[x] = 1'b0;
          share = n / newc;
          k = 0;
          for (int j = oldc; j < newc; j++) begin
            for (int i = 0; i < share; i++) begin
              // donor: last core holding the largest load
              c = 0;
              v = 0;
              for (int x = 0; x < oldc; x++)
                if (int'(load[x]) >= v) begin
                  v = int'(load[x]);
                  c = x;
                end
              // scan position carries over between transfers
              found = 0;
              for (int t = 0; t < n; t++) begin
                if (int'(steer[k]) == c) begin
                  found = 1;
                  break;
                end
                k = (k + 1) % n;
              end
              if (found) begin
                steer[k] = CORE_W'(j);
                mark[k] = 1'b1;
                if (load[c] > 0) load[c]--;
                if (load[j] < LOAD_MAX) load[j]++;
                moved++;
              end
            end
          end
          r.changed_count = CNT_W'(moved);
        end
      end
      OP_DOWN: begin
        if (newc == 0 || newc >= oldc || oldc > MAX_CORES) begin
          r.status = 1'b1;
        end else begin
          foreach (mark[x]) mark[x] = 1'b0;
          for (int i = 0; i < n; i++) begin
            oc = int'(steer[i]);
            if (oc >= newc) begin
              // first core with the true minimum load
              nc = 0;
              for (int x = 1; x < newc; x++)
                if (load[x] < load[nc]) nc = x;
              steer[i] = CORE_W'(nc);
              mark[i] = 1'b1;
              if (load[oc] > 0) load[oc]--;
              if (load[nc] < LOAD_MAX) load[nc]++;
              moved++;
            end
          end
          r.changed_count = CNT_W'(moved);
        end
      end
      default: begin
        r.entry_core = steer[w.entry_index];
        r.entry_changed = mark[w.entry_index];
        r.core_count = load[w.core_query];
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      tbl_entries = 8'd128;
      cores_used = 5'd1;
      foreach (steer[x]) steer[x] = '0;
      foreach (mark[x]) mark[x] = 1'b0;
      foreach (load[x]) load[x] = '0;
      load[0] = 8'd128;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TABLE_ENTRIES) tbl_entries = cfg_wdata;
        else cores_used = cfg_wdata[4:0];
      end
      if (in_valid && !in_stall) expected_q.push_back(rebalance(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word, actual %p", $time, out_data);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          check_field("status", e.status, out_data.status);
          check_field("changed_count", e.changed_count, out_data.changed_count);
          check_field("entry_core", e.entry_core, out_data.entry_core);
          check_field("entry_changed", e.entry_changed, out_data.entry_changed);
          check_field("core_count", e.core_count, out_data.core_count);
        end
      end
    end
    outstanding = expected_q.size();
  end
endmodule

// File: bench/tb_rss_redirection_rebalancer.sv
// Top of the rebalancer bench: clock, reset, config writes, command stimulus, verdict.
// Depends on rssrb_pkg, rss_redirection_rebalancer and rssrb_checker.
module tb_rss_redirection_rebalancer;
  import rssrb_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  in_t              in_data;
  logic             out_valid;
  logic             out_stall;
  out_t             out_data;
  int               fail_count;
  int               outstanding;

  // sender burst shaping
  int burst_left;
  int sent;
  // receiver stall pattern
  int stall_mode;
  int stall_left;

  rss_redirection_rebalancer dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  rssrb_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: worst case is a few full-table scale-ups plus stalls;
  // this is many times the slowest expected run.
  initial begin
    #300000000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: alternates between no stall, coin-flip stall and mostly-stalled spans.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(1, 40);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  function automatic in_t cmd(op_t op, int oldc, int newc, int idx, int q);
    in_t w;
    w.op = op;
    w.old_cores = NCORE_W'(oldc);
    w.new_cores = NCORE_W'(newc);
    w.entry_index = ADDR_W'(idx);
    w.core_query = CORE_W'(q);
    return w;
  endfunction

  // One word: optional gap at a burst boundary, then hold valid until taken.
  task automatic send(in_t w);
    @(posedge clk);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    in_valid <= 1'b0;
    sent++;
  endtask

  task automatic read_rand();
    send(cmd(OP_READ, $urandom_range(0, 31), $urandom_range(0, 31),
             $urandom_range(0, 127), $urandom_range(0, 15)));
  endtask

  // Wait until every expected result word has come back.
  task automatic drain();
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, int val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int cur, nxt, te_pick;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_TABLE_ENTRIES;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    burst_left = 0;
    sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset contents: core 0 owns everything
    send(cmd(OP_READ, 0, 0, 0, 0));
    send(cmd(OP_READ, 31, 31, 127, 15));

    // small table, four cores
    cfg_write(CFG_TABLE_ENTRIES, 8);
    cfg_write(CFG_CORES_IN_USE, 4);
    send(cmd(OP_INIT, 0, 0, 0, 0));
    send(cmd(OP_READ, 0, 0, 3, 3));
    send(cmd(OP_UP, 4, 8, 0, 0));
    send(cmd(OP_READ, 0, 0, 5, 7));
    send(cmd(OP_DOWN, 8, 2, 0, 0));
    send(cmd(OP_READ, 0, 0, 7, 1));
    // malformed core counts are rejected, marks kept
    send(cmd(OP_UP, 0, 5, 0, 0));
    send(cmd(OP_UP, 5, 5, 0, 0));
    send(cmd(OP_UP, 3, 17, 0, 0));
    send(cmd(OP_DOWN, 3, 0, 0, 0));
    send(cmd(OP_DOWN, 3, 3, 0, 0));
    send(cmd(OP_DOWN, 17, 2, 0, 0));
    send(cmd(OP_UP, 31, 31, 0, 0));
    send(cmd(OP_READ, 0, 0, 6, 0));

    // full table across the widest core range
    cfg_write(CFG_TABLE_ENTRIES, 128);
    cfg_write(CFG_CORES_IN_USE, 16);
    send(cmd(OP_INIT, 0, 0, 0, 0));
    send(cmd(OP_DOWN, 16, 1, 0, 0));
    send(cmd(OP_UP, 1, 16, 0, 0));
    send(cmd(OP_READ, 0, 0, 127, 15));

    // bad init counts
    cfg_write(CFG_CORES_IN_USE, 0);
    send(cmd(OP_INIT, 0, 0, 0, 0));
    cfg_write(CFG_CORES_IN_USE, 31);
    send(cmd(OP_INIT, 0, 0, 0, 0));

    // empty table, then oversize value clamped to the table depth
    cfg_write(CFG_TABLE_ENTRIES, 0);
    send(cmd(OP_UP, 1, 4, 0, 0));
    send(cmd(OP_DOWN, 16, 1, 0, 0));
    cfg_write(CFG_TABLE_ENTRIES, 255);
    cfg_write(CFG_CORES_IN_USE, 1);
    send(cmd(OP_INIT, 0, 0, 0, 0));
    read_rand();

    // Random phases: mostly a well-formed init/scale chain on a small table,
    // with reads between steps and some noise words.
    while (sent < 130) begin
      te_pick = $urandom_range(0, 19);
      cfg_write(CFG_TABLE_ENTRIES,
                te_pick < 15 ? (1 << $urandom_range(0, 5)) :
                te_pick < 17 ? (1 << $urandom_range(6, 7)) :
                te_pick < 19 ? $urandom_range(0, 255) : 0);
      cur = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      cfg_write(CFG_CORES_IN_USE, cur);
      send(cmd(OP_INIT, $urandom_range(0, 31), $urandom_range(0, 31), 0, 0));
      if (cur < 1 || cur > 16) cur = 1;
      repeat ($urandom_range(3, 8)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: if (cur < 16) begin
            nxt = $urandom_range(cur + 1, 16);
            send(cmd(OP_UP, cur, nxt, $urandom_range(0, 127), $urandom_range(0, 15)));
            cur = nxt;
          end
          3, 4, 5: if (cur > 1) begin
            nxt = $urandom_range(1, cur - 1);
            send(cmd(OP_DOWN, cur, nxt, $urandom_range(0, 127), $urandom_range(0, 15)));
            cur = nxt;
          end
          6, 7: read_rand();
          default: send(cmd(op_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                            $urandom_range(0, 31), $urandom_range(0, 127),
                            $urandom_range(0, 15)));
        endcase
        if ($urandom_range(0, 1)) read_rand();
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
